[design/char_lcd_nibble_sequencer_defines.svh]
// Assertion macros used by the step counter (clns_sequencer) of the nibble sequencer RTL.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// Checked out of reset only.
`define CLNS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define CLNS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[design/clns_pkg.sv]
// Types, constants and microcode table of the LCD nibble sequencer.
`default_nettype none

package clns_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned ValueW = 8;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned ColW   = 6;
  localparam int unsigned NibW   = 4;
  localparam int unsigned AddrW  = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_NIBBLE = 3'd0,
    MODE_BYTE   = 3'd1,
    MODE_CHAR   = 3'd2,
    MODE_CURSOR = 3'd3,
    MODE_CLEAR  = 3'd4,
    MODE_INIT   = 3'd5
  } mode_e;

  localparam logic [HoldW-1:0]  PulseUs   = 16'd5;
  localparam logic [HoldW-1:0]  IdleUs    = 16'd15000;
  localparam logic [HoldW-1:0]  Wake1Us   = 16'd4100;
  localparam logic [HoldW-1:0]  WakeUs    = 16'd100;
  localparam logic [HoldW-1:0]  SetupUs   = 16'd53;
  localparam logic [HoldW-1:0]  ClearUs   = 16'd3000;
  localparam logic [HoldW-1:0]  CharUs    = 16'd46;
  localparam logic [ValueW-1:0] CursorCmd = 8'h80;
  localparam logic [ValueW-1:0] ClearCmd  = 8'h01;
  localparam logic [AddrW-1:0]  Row1Base  = 7'h40;

  localparam int unsigned UcDepth = 40;
  localparam int unsigned PcW     = $clog2(UcDepth);

  localparam logic [PcW-1:0] UcNibble = PcW'(0);
  localparam logic [PcW-1:0] UcByte   = PcW'(3);
  localparam logic [PcW-1:0] UcInit   = PcW'(7);

  typedef enum logic [1:0] {
    NIB_LO    = 2'd0,
    NIB_HI    = 2'd1,
    NIB_CONST = 2'd2
  } nib_sel_e;

  typedef enum logic [2:0] {
    HOLD_PULSE = 3'd0,
    HOLD_ZERO  = 3'd1,
    HOLD_REQ   = 3'd2,
    HOLD_IDLE  = 3'd3,
    HOLD_WAKE1 = 3'd4,
    HOLD_WAKE  = 3'd5,
    HOLD_SETUP = 3'd6,
    HOLD_CLEAR = 3'd7
  } hold_sel_e;

  typedef struct packed {
    nib_sel_e          nib_sel;
    logic [NibW-1:0]   cnib;
    logic              rs_req;
    logic              en;
    hold_sel_e         hold_sel;
    logic              last;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic   busy;
    logic   fire;
    uword_t word;
  } seq_stat_t;

  // Datapath to sequencer
  typedef struct packed {
    logic           start;
    logic [PcW-1:0] entry;
    logic           slot_free;
  } seq_req_t;

  function automatic uword_t uw(nib_sel_e sel, logic [NibW-1:0] c, logic rs,
                                logic en, hold_sel_e hs, logic last);
    uword_t w;
    w.nib_sel  = sel;
    w.cnib     = c;
    w.rs_req   = rs;
    w.en       = en;
    w.hold_sel = hs;
    w.last     = last;
    return w;
  endfunction

  function automatic logic [HoldW-1:0] hold_value(hold_sel_e hs,
                                                  logic [HoldW-1:0] req_wait);
    logic [HoldW-1:0] h;
    unique case (hs)
      HOLD_PULSE: h = PulseUs;
      HOLD_ZERO:  h = '0;
      HOLD_REQ:   h = req_wait;
      HOLD_IDLE:  h = IdleUs;
      HOLD_WAKE1: h = Wake1Us;
      HOLD_WAKE:  h = WakeUs;
      HOLD_SETUP: h = SetupUs;
      HOLD_CLEAR: h = ClearUs;
      default:    h = '0;
    endcase
    return h;
  endfunction

  // Microcode: request nibble, request byte, then the power-up program.
  function automatic uword_t ucode(logic [PcW-1:0] pc);
    uword_t w;
    unique case (pc)
      // nibble command
      6'd0:  w = uw(NIB_LO,    4'h0, 1'b0, 1'b0, HOLD_PULSE, 1'b0);
      6'd1:  w = uw(NIB_LO,    4'h0, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd2:  w = uw(NIB_LO,    4'h0, 1'b0, 1'b0, HOLD_REQ,   1'b1);
      // byte transfer
      6'd3:  w = uw(NIB_HI,    4'h0, 1'b1, 1'b1, HOLD_PULSE, 1'b0);
      6'd4:  w = uw(NIB_LO,    4'h0, 1'b1, 1'b0, HOLD_ZERO,  1'b0);
      6'd5:  w = uw(NIB_LO,    4'h0, 1'b1, 1'b1, HOLD_PULSE, 1'b0);
      6'd6:  w = uw(NIB_LO,    4'h0, 1'b1, 1'b0, HOLD_REQ,   1'b1);
      // power-up: idle, then wake-up nibbles
      6'd7:  w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_IDLE,  1'b0);
      6'd8:  w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE, 1'b0);
      6'd9:  w = uw(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd10: w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_WAKE1, 1'b0);
      6'd11: w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE, 1'b0);
      6'd12: w = uw(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd13: w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_WAKE,  1'b0);
      6'd14: w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_PULSE, 1'b0);
      6'd15: w = uw(NIB_CONST, 4'h3, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd16: w = uw(NIB_CONST, 4'h3, 1'b0, 1'b0, HOLD_WAKE,  1'b0);
      6'd17: w = uw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_PULSE, 1'b0);
      6'd18: w = uw(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd19: w = uw(NIB_CONST, 4'h2, 1'b0, 1'b0, HOLD_WAKE,  1'b0);
      // function set 0x28
      6'd20: w = uw(NIB_CONST, 4'h2, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd21: w = uw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_ZERO,  1'b0);
      6'd22: w = uw(NIB_CONST, 4'h8, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd23: w = uw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_SETUP, 1'b0);
      // display off 0x08
      6'd24: w = uw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd25: w = uw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_ZERO,  1'b0);
      6'd26: w = uw(NIB_CONST, 4'h8, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd27: w = uw(NIB_CONST, 4'h8, 1'b0, 1'b0, HOLD_SETUP, 1'b0);
      // clear 0x01
      6'd28: w = uw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd29: w = uw(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_ZERO,  1'b0);
      6'd30: w = uw(NIB_CONST, 4'h1, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd31: w = uw(NIB_CONST, 4'h1, 1'b0, 1'b0, HOLD_CLEAR, 1'b0);
      // entry mode 0x06
      6'd32: w = uw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd33: w = uw(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_ZERO,  1'b0);
      6'd34: w = uw(NIB_CONST, 4'h6, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd35: w = uw(NIB_CONST, 4'h6, 1'b0, 1'b0, HOLD_SETUP, 1'b0);
      // display on 0x0C
      6'd36: w = uw(NIB_CONST, 4'h0, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd37: w = uw(NIB_CONST, 4'hC, 1'b0, 1'b0, HOLD_ZERO,  1'b0);
      6'd38: w = uw(NIB_CONST, 4'hC, 1'b0, 1'b1, HOLD_PULSE, 1'b0);
      6'd39: w = uw(NIB_CONST, 4'hC, 1'b0, 1'b0, HOLD_SETUP, 1'b1);
      default: w = uw(NIB_CONST, 4'h0, 1'b0, 1'b0, HOLD_ZERO, 1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/clns_if.sv]
// Request and pin-setting channel interfaces.
`default_nettype none

interface clns_req_if;
  import clns_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ModeW-1:0]     mode;
  logic [ValueW-1:0]    value;
  logic [HoldW-1:0]     delay_us;
  logic [ColW-1:0]      col;
  logic                 row;

  modport source (output valid, mode, value, delay_us, col, row, input ready);
  modport sink   (input valid, mode, value, delay_us, col, row, output ready);
endinterface

interface clns_rsp_if;
  import clns_pkg::*;
  logic               valid;
  logic               ready;
  logic [NibW-1:0]    nibble;
  logic               reg_select;
  logic               enable;
  logic [HoldW-1:0]   hold_us;
  logic               last;

  modport source (output valid, nibble, reg_select, enable, hold_us, last,
                  input ready);
  modport sink   (input valid, nibble, reg_select, enable, hold_us, last,
                  output ready);
endinterface

`default_nettype wire

[design/char_lcd_nibble_sequencer.sv]
// Top level: 4-bit character LCD pin sequencer, microcoded.
//
//   channel  dir  handshake        word
//   req_i    in   valid/ready      mode, value, delay_us, col, row
//   rsp_o    out  valid/ready      nibble, reg_select, enable, hold_us, last
//
// One pin setting leaves per cycle from the microcode step counter unless rsp_o
// stalls, so a request gives 3 (nibble), 4 (byte, character, cursor, clear) or
// 33 (init) pin settings; unused modes are accepted and give none.
// A new request is taken once the last word of the run is in the output register.
// A stall on rsp_o freezes the step counter; reset clears the run and output valid.
`default_nettype none

module char_lcd_nibble_sequencer
  import clns_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  clns_req_if.sink    req_i,
  clns_rsp_if.source  rsp_o
);

  seq_stat_t stat;
  seq_req_t  ctl;

  clns_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ctl),
    .stat_o (stat)
  );

  clns_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

endmodule

`default_nettype wire

[design/clns_sequencer.sv]
// Step counter and microcode fetch of the nibble sequencer.
`default_nettype none

`include "char_lcd_nibble_sequencer_defines.svh"

module clns_sequencer
  import clns_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire seq_req_t  req_i,
  output seq_stat_t      stat_o
);

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  uword_t         word;
  logic           fire;

  always_comb begin
    word = ucode(pc_q);
    fire = busy_q && req_i.slot_free;
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    priority if (req_i.start) begin
      busy_d = 1'b1;
      pc_d   = req_i.entry;
    end else if (fire) begin
      // last word ends the run; the step counter steps on either way
      if (word.last) begin
        busy_d = 1'b0;
      end
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.fire = fire;
  assign stat_o.word = word;

  `CLNS_ASSERT_ALWAYS(a_idle_in_reset, !rst_ni |=> !busy_q, "busy while in reset")
  `CLNS_ASSERT(a_start_runs, req_i.start |=> busy_q, "start did not begin a run")
  `CLNS_ASSERT(a_last_ends, (fire && word.last) |=> !busy_q, "run kept going after last")
  `CLNS_ASSERT(a_step, (fire && !word.last) |=> (pc_q == PcW'($past(pc_q) + 1'b1)), "bad step")
  `CLNS_ASSERT(a_stall_hold, (busy_q && !fire) |=> $stable(pc_q), "step moved under stall")
  `CLNS_ASSERT(a_pc_range, busy_q |-> (pc_q < PcW'(UcDepth)), "step counter out of table")

endmodule

`default_nettype wire

[design/clns_datapath.sv]
// Request decode, operand registers and pin-setting output register.
`default_nettype none

module clns_datapath
  import clns_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  clns_req_if.sink        req_i,
  clns_rsp_if.source      rsp_o,
  input  wire seq_stat_t  stat_i,
  output seq_req_t        ctl_o
);

  logic [ValueW-1:0] op_q, op_d;
  logic              rs_q, rs_d;
  logic [HoldW-1:0]  wait_q, wait_d;
  logic              acc;
  logic [AddrW-1:0]  addr;
  logic              start;
  logic [PcW-1:0]    entry;

  logic              out_valid_q;
  logic [NibW-1:0]   nib_q, nib_d;
  logic              rs_out_q;
  logic              en_q;
  logic [HoldW-1:0]  hold_q;
  logic              last_q;

  assign req_i.ready = !stat_i.busy;
  assign acc         = req_i.valid && req_i.ready;

  always_comb begin
    addr   = {1'b0, req_i.col} + (req_i.row ? Row1Base : '0);
    op_d   = req_i.value;
    rs_d   = 1'b0;
    wait_d = req_i.delay_us;
    start  = acc;
    entry  = UcByte;
    unique case (mode_e'(req_i.mode))
      MODE_NIBBLE: entry = UcNibble;
      MODE_BYTE:   entry = UcByte;
      MODE_CHAR: begin
        rs_d   = 1'b1;
        wait_d = CharUs;
      end
      MODE_CURSOR: begin
        op_d   = CursorCmd | {1'b0, addr};
        wait_d = CharUs;
      end
      MODE_CLEAR: begin
        op_d   = ClearCmd;
        wait_d = ClearUs;
      end
      MODE_INIT:   entry = UcInit;
      default:     start = 1'b0;   // unused modes give no words
    endcase
  end

  assign ctl_o.start     = start;
  assign ctl_o.entry     = entry;
  assign ctl_o.slot_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      op_q   <= op_d;
      rs_q   <= rs_d;
      wait_q <= wait_d;
    end
  end

  always_comb begin
    unique case (stat_i.word.nib_sel)
      NIB_LO:    nib_d = op_q[NibW-1:0];
      NIB_HI:    nib_d = op_q[ValueW-1:NibW];
      NIB_CONST: nib_d = stat_i.word.cnib;
      default:   nib_d = stat_i.word.cnib;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stat_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_i.fire) begin
      nib_q    <= nib_d;
      rs_out_q <= stat_i.word.rs_req && rs_q;
      en_q     <= stat_i.word.en;
      hold_q   <= hold_value(stat_i.word.hold_sel, wait_q);
      last_q   <= stat_i.word.last;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.nibble     = nib_q;
  assign rsp_o.reg_select = rs_out_q;
  assign rsp_o.enable     = en_q;
  assign rsp_o.hold_us    = hold_q;
  assign rsp_o.last       = last_q;

endmodule

`default_nettype wire

[verif/clns_pin_checker.sv]
// Checker for the LCD nibble sequencer: predicts pin words per request and compares them.
`default_nettype none

module clns_pin_checker
  import clns_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  clns_req_if         req_i,
  clns_rsp_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NibW-1:0]  nibble;
    logic             reg_select;
    logic             enable;
    logic [HoldW-1:0] hold_us;
    logic             last;
  } pin_word_t;

  localparam logic [HoldW-1:0]  StrobeUs      = 16'd5;
  localparam logic [HoldW-1:0]  PowerUpUs     = 16'd15000;
  localparam logic [HoldW-1:0]  Wake1WaitUs   = 16'd4100;
  localparam logic [HoldW-1:0]  WakeWaitUs    = 16'd100;
  localparam logic [HoldW-1:0]  SetupWaitUs   = 16'd53;
  localparam logic [HoldW-1:0]  ClearWaitUs   = 16'd3000;
  localparam logic [HoldW-1:0]  CharWaitUs    = 16'd46;
  localparam logic [ValueW-1:0] DdramCmd      = 8'h80;
  localparam logic [ValueW-1:0] ClearDispCmd  = 8'h01;
  localparam logic [ValueW-1:0] FuncSetCmd    = 8'h28;
  localparam logic [ValueW-1:0] DisplayOffCmd = 8'h08;
  localparam logic [ValueW-1:0] EntryModeCmd  = 8'h06;
  localparam logic [ValueW-1:0] DisplayOnCmd  = 8'h0C;
  localparam logic [AddrW-1:0]  Row1Addr      = 7'h40;
  localparam logic [NibW-1:0]   WakeNib       = 4'h3;
  localparam logic [NibW-1:0]   BusWidthNib   = 4'h2;

  pin_word_t expected_pins_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void push_pin(logic [NibW-1:0] nib, logic rs, logic en,
                                   logic [HoldW-1:0] hold);
    pin_word_t w;
    w.nibble     = nib;
    w.reg_select = rs;
    w.enable     = en;
    w.hold_us    = hold;
    w.last       = 1'b0;
    expected_pins_q.push_back(w);
  endfunction

  function automatic void push_nibble_cmd(logic [NibW-1:0] nib, logic [HoldW-1:0] hold);
    push_pin(nib, 1'b0, 1'b0, StrobeUs);
    push_pin(nib, 1'b0, 1'b1, StrobeUs);
    push_pin(nib, 1'b0, 1'b0, hold);
  endfunction

  // High nibble rides on the first strobe; the low nibble is set up, strobed and held.
  function automatic void push_byte(logic [ValueW-1:0] b, logic rs, logic [HoldW-1:0] hold);
    push_pin(b[7:4], rs, 1'b1, StrobeUs);
    push_pin(b[3:0], rs, 1'b0, '0);
    push_pin(b[3:0], rs, 1'b1, StrobeUs);
    push_pin(b[3:0], rs, 1'b0, hold);
  endfunction

  function automatic void predict_request(logic [ModeW-1:0] mode, logic [ValueW-1:0] value,
                                          logic [HoldW-1:0] delay_us, logic [ColW-1:0] col,
                                          logic row);
    logic [AddrW-1:0] addr;
    pin_word_t        tail;
    // columns past 39 are added as they are; col plus 0x40 still fits in 7 bits
    addr = AddrW'(col) + (row ? Row1Addr : '0);
    case (mode)
      MODE_NIBBLE: push_nibble_cmd(value[3:0], delay_us);
      MODE_BYTE:   push_byte(value, 1'b0, delay_us);
      MODE_CHAR:   push_byte(value, 1'b1, CharWaitUs);
      MODE_CURSOR: push_byte(DdramCmd | {1'b0, addr}, 1'b0, CharWaitUs);
      MODE_CLEAR:  push_byte(ClearDispCmd, 1'b0, ClearWaitUs);
      MODE_INIT: begin
        push_pin('0, 1'b0, 1'b0, PowerUpUs);
        push_nibble_cmd(WakeNib, Wake1WaitUs);
        push_nibble_cmd(WakeNib, WakeWaitUs);
        push_nibble_cmd(WakeNib, WakeWaitUs);
        push_nibble_cmd(BusWidthNib, WakeWaitUs);
        push_byte(FuncSetCmd, 1'b0, SetupWaitUs);
        push_byte(DisplayOffCmd, 1'b0, SetupWaitUs);
        push_byte(ClearDispCmd, 1'b0, ClearWaitUs);
        push_byte(EntryModeCmd, 1'b0, SetupWaitUs);
        push_byte(DisplayOnCmd, 1'b0, SetupWaitUs);
      end
      default: return;  // spare modes give nothing
    endcase
    tail = expected_pins_q.pop_back();
    tail.last = 1'b1;
    expected_pins_q.push_back(tail);
  endfunction

  always @(posedge clk_i) begin
    pin_word_t got;
    pin_word_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        predict_request(req_i.mode, req_i.value, req_i.delay_us, req_i.col, req_i.row);
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.nibble     = rsp_i.nibble;
        got.reg_select = rsp_i.reg_select;
        got.enable     = rsp_i.enable;
        got.hold_us    = rsp_i.hold_us;
        got.last       = rsp_i.last;
        if (expected_pins_q.size() == 0) begin
          $display("%0t: pin word with nothing expected: nib=%h rs=%b en=%b hold=%0d last=%b",
                   $time, got.nibble, got.reg_select, got.enable, got.hold_us, got.last);
          fail_count_o++;
        end else begin
          want = expected_pins_q.pop_front();
          if (got !== want) begin
            $display("%0t: pin word mismatch: expected nib=%h rs=%b en=%b hold=%0d last=%b",
                     $time, want.nibble, want.reg_select, want.enable, want.hold_us,
                     want.last);
            $display("%0t:                      actual nib=%h rs=%b en=%b hold=%0d last=%b",
                     $time, got.nibble, got.reg_select, got.enable, got.hold_us, got.last);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_pins_q.size();
  end

endmodule

`default_nettype wire

[verif/tb_char_lcd_nibble_sequencer.sv]
// Testbench top for the LCD nibble sequencer: clock, reset, request stimulus, verdict.
`default_nettype none

module tb_char_lcd_nibble_sequencer
  import clns_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod  = 8;
  localparam int unsigned RandItems  = 160;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxGap     = 13;
  localparam int unsigned TailCycles = 60;

  localparam logic [ModeW-1:0] ModeSpare6 = 3'd6;
  localparam logic [ModeW-1:0] ModeSpare7 = 3'd7;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        sink_ready = 1'b0;
  bit          req_calm   = 1'b0;
  bit          rsp_calm   = 1'b0;
  bit          rsp_took   = 1'b0;
  int unsigned sink_gap   = 0;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;

  clns_req_if req_if ();
  clns_rsp_if rsp_if ();

  assign rsp_if.ready = sink_ready;

  char_lcd_nibble_sequencer u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  clns_pin_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sink side: a fresh stall is drawn after every word taken.
  always @(posedge clk_i) rsp_took <= rsp_if.valid && rsp_if.ready;

  always @(negedge clk_i) begin
    if (rsp_took) sink_gap = rsp_calm ? 0 : $urandom_range(0, MaxGap);
    if (!rst_ni) begin
      sink_ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_ready <= 1'b0;
      sink_gap--;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_request(logic [ModeW-1:0] mode, logic [ValueW-1:0] value,
                              logic [HoldW-1:0] delay_us, logic [ColW-1:0] col,
                              logic row);
    int unsigned gap;
    gap = req_calm ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      req_if.valid    <= 1'b0;
      req_if.mode     <= ModeW'($urandom());
      req_if.value    <= ValueW'($urandom());
      req_if.delay_us <= HoldW'($urandom());
      req_if.col      <= ColW'($urandom());
      req_if.row      <= 1'($urandom());
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= mode;
    req_if.value    <= value;
    req_if.delay_us <= delay_us;
    req_if.col      <= col;
    req_if.row      <= row;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Hold off until every expected word is out.
  task automatic drain_pins();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  initial begin
    logic [ModeW-1:0]  mode;
    logic [ValueW-1:0] value;
    logic [HoldW-1:0]  delay_us;
    logic [ColW-1:0]   col;
    int unsigned       pick;

    req_if.valid    = 1'b0;
    req_if.mode     = '0;
    req_if.value    = '0;
    req_if.delay_us = '0;
    req_if.col      = '0;
    req_if.row      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every mode, columns past 39, spare modes
    send_request(MODE_NIBBLE, 8'h00, 16'h0000, 6'd0, 1'b0);
    send_request(MODE_NIBBLE, 8'hFF, 16'hFFFF, 6'd63, 1'b1);
    send_request(MODE_NIBBLE, 8'hA5, 16'h8001, 6'd5, 1'b0);
    send_request(MODE_BYTE, 8'h00, 16'h0000, 6'd0, 1'b0);
    send_request(MODE_BYTE, 8'hFF, 16'hFFFF, 6'd63, 1'b1);
    send_request(MODE_BYTE, 8'h5A, 16'h7FFE, 6'd12, 1'b0);
    send_request(MODE_CHAR, 8'h00, 16'hFFFF, 6'd63, 1'b1);
    send_request(MODE_CHAR, 8'hFF, 16'h0000, 6'd0, 1'b0);
    send_request(MODE_CHAR, 8'h41, 16'h1234, 6'd20, 1'b1);
    send_request(MODE_CURSOR, 8'hFF, 16'hFFFF, 6'd0, 1'b0);
    send_request(MODE_CURSOR, 8'h00, 16'h0000, 6'd39, 1'b1);
    send_request(MODE_CURSOR, 8'h3C, 16'h0042, 6'd63, 1'b1);
    send_request(MODE_CURSOR, 8'hC3, 16'hBEEF, 6'd63, 1'b0);
    send_request(MODE_CURSOR, 8'h11, 16'h0001, 6'd40, 1'b0);
    send_request(MODE_CLEAR, 8'hFF, 16'hFFFF, 6'd63, 1'b1);
    send_request(MODE_CLEAR, 8'h00, 16'h0000, 6'd0, 1'b0);
    send_request(MODE_INIT, 8'hFF, 16'hFFFF, 6'd63, 1'b1);
    send_request(ModeSpare6, 8'hFF, 16'hFFFF, 6'd63, 1'b1);
    send_request(ModeSpare7, 8'h00, 16'h0000, 6'd0, 1'b0);
    send_request(MODE_INIT, 8'h00, 16'h0000, 6'd0, 1'b0);
    drain_pins();

    for (int i = 0; i < RandItems; i++) begin
      if (i % 40 == 0) begin
        // one stretch runs flat out on both sides
        req_calm = (i == 80) || ($urandom_range(0, 3) == 0);
        rsp_calm = (i == 80) || ($urandom_range(0, 3) == 0);
      end
      if (i == RandItems / 2 || i == RandItems / 4) drain_pins();
      pick = $urandom_range(0, 99);
      if (pick < 5) mode = MODE_INIT;
      else if (pick < 10) mode = $urandom_range(0, 1) ? ModeSpare6 : ModeSpare7;
      else mode = ModeW'($urandom_range(MODE_NIBBLE, MODE_CLEAR));
      value    = ValueW'($urandom());
      delay_us = ($urandom_range(0, 3) == 0) ? HoldW'($urandom_range(0, 15))
                                              : HoldW'($urandom());
      col      = ($urandom_range(0, 7) == 0) ? ColW'($urandom_range(40, 63))
                                              : ColW'($urandom_range(0, 39));
      send_request(mode, value, delay_us, col, 1'($urandom()));
    end

    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (TailCycles) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+design
design/clns_pkg.sv
design/clns_if.sv
design/clns_sequencer.sv
design/clns_datapath.sv
design/char_lcd_nibble_sequencer.sv
verif/clns_pin_checker.sv
verif/tb_char_lcd_nibble_sequencer.sv
